// ----- rtl/core/gtrav_pkg.sv -----
`default_nettype none

package gtrav_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 7;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_VERTICES     = 32;
    localparam int DEF_MAX_EDGE_ENTRIES = 256;

    // Vertex count after reset, clipped to the vertex capacity
    localparam int VCOUNT_DEFAULT = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BFS      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DFS      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } in_item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] visited_vertex;
        logic                last;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/graph_bfs_dfs_traversal.sv -----
// Undirected graph store with breadth-first and depth-first walks. An add-edge item
// (cmd 0) prepends each endpoint to the other's neighbour list, so lists run newest
// first, and answers with one item of status ok; an endpoint not below vertex_count
// answers status 1, and fewer than two free edge entries answers status 2, leaving
// the graph untouched. A walk item (cmd 1 breadth-first, cmd 2 depth-first) answers
// with one item per reached vertex in visit order, last set on the final one; a bad
// start vertex answers a single status 1 item. Command 3 is dropped without a
// result. Writing vertex_count on the cfg channel (zero reads as 1, values above
// MAX_VERTICES clip to it) empties the graph at once. Adjacency lives in a link
// memory with one read port, holding MAX_EDGE_ENTRIES entries plus one list head
// per vertex; the queue or stack lives in a second memory. Items are handled one
// at a time. An edge reads the owner's list head, writes a new entry, then writes
// the head, once for each endpoint, before its result. A walk is paced by the
// single link-memory read port that follows each list one entry per cycle; output
// stalls slow it further. A finished result waits in an output register, so the
// next item can be taken while it is unread.

`default_nettype none

module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES     = gtrav_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGE_ENTRIES = gtrav_pkg::DEF_MAX_EDGE_ENTRIES
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  gtrav_pkg::in_item_t            s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output gtrav_pkg::out_item_t           m_data,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [gtrav_pkg::VCOUNT_W-1:0]  cfg_wdata
);

    // Engine to output register
    logic                 eng_res_valid;
    logic                 eng_res_ready;
    gtrav_pkg::out_item_t eng_res;

    // Sequencer and both memories: edge insertion, walks, configuration
    gtrav_engine #(
        .MAX_VERTICES     (MAX_VERTICES),
        .MAX_EDGE_ENTRIES (MAX_EDGE_ENTRIES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_valid),
        .item_ready (s_ready),
        .item       (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_wdata  (cfg_wdata),
        .res_valid  (eng_res_valid),
        .res_ready  (eng_res_ready),
        .res        (eng_res)
    );

    // Hold each result item until the consumer takes it
    gtrav_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (eng_res_valid),
        .in_ready (eng_res_ready),
        .in_data  (eng_res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A real command leaves the idle state, so no second item is taken next cycle
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.cmd != gtrav_pkg::CMD_NONE) |=> !s_ready && !cfg_ready
    ) else $error("item taken while a previous item was still in progress");

    // Error results are single items carrying vertex zero
    a_error_shape: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != gtrav_pkg::ST_OK) |-> m_data.last &&
        (m_data.visited_vertex == '0)
    ) else $error("error result not marked last or vertex not zero");

    // Handing over the final result returns the engine to idle
    a_idle_after_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        eng_res_valid && eng_res_ready && eng_res.last |=> cfg_ready
    ) else $error("engine not idle after its final result");

    // Status codes above edge-store-full never appear
    a_status_code: assert property (
        @(posedge aclk) disable iff (!aresetn)
        eng_res_valid |-> (eng_res.status == gtrav_pkg::ST_OK) ||
        (eng_res.status == gtrav_pkg::ST_RANGE) || (eng_res.status == gtrav_pkg::ST_FULL)
    ) else $error("undefined status code on a result");

endmodule

`default_nettype wire

// ----- rtl/core/gtrav_out_reg.sv -----
`default_nettype none

module gtrav_out_reg (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  gtrav_pkg::out_item_t  in_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output gtrav_pkg::out_item_t  m_data
);

    logic                 valid_reg;
    logic                 valid_next;
    gtrav_pkg::out_item_t data_reg;

    // Take a new item whenever the register is empty or being drained
    assign in_ready   = !valid_reg || m_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gtrav_engine.sv -----
`default_nettype none

module gtrav_engine #(
    parameter int MAX_VERTICES     = gtrav_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGE_ENTRIES = gtrav_pkg::DEF_MAX_EDGE_ENTRIES
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               item_valid,
    output logic                              item_ready,
    input  gtrav_pkg::in_item_t               item,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [gtrav_pkg::VCOUNT_W-1:0]     cfg_wdata,
    output logic                              res_valid,
    input  wire                               res_ready,
    output gtrav_pkg::out_item_t              res
);

    localparam int VW      = gtrav_pkg::VERTEX_W;
    localparam int CW      = gtrav_pkg::VCOUNT_W;
    localparam int LINK_W  = $clog2(MAX_EDGE_ENTRIES + 1);
    localparam int LDEPTH  = MAX_EDGE_ENTRIES + MAX_VERTICES;
    localparam int LADDR_W = $clog2(LDEPTH);
    localparam int LWORD_W = VW + LINK_W;
    localparam int WDEPTH  = MAX_EDGE_ENTRIES + 1;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int CNT_W   = $clog2(WDEPTH + 1);
    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int VC_RST  = (MAX_VERTICES < gtrav_pkg::VCOUNT_DEFAULT) ?
                             MAX_VERTICES : gtrav_pkg::VCOUNT_DEFAULT;

    localparam logic [LINK_W-1:0]  NIL       = LINK_W'(MAX_EDGE_ENTRIES);
    localparam logic [LADDR_W-1:0] HEAD_BASE = LADDR_W'(MAX_EDGE_ENTRIES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_E_RD   = 4'd1;
    localparam logic [3:0] S_E_WE   = 4'd2;
    localparam logic [3:0] S_E_WH   = 4'd3;
    localparam logic [3:0] S_W_POP  = 4'd4;
    localparam logic [3:0] S_W_GET  = 4'd5;
    localparam logic [3:0] S_W_VIS  = 4'd6;
    localparam logic [3:0] S_W_HEAD = 4'd7;
    localparam logic [3:0] S_W_SCAN = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    // Link memory: edge entries at the bottom, list heads above them
    logic [LWORD_W-1:0] link_mem [LDEPTH];
    logic [LWORD_W-1:0] link_rd_reg;
    logic               link_we;
    logic [LADDR_W-1:0] link_waddr;
    logic [LWORD_W-1:0] link_wdata;
    logic               link_re;
    logic [LADDR_W-1:0] link_raddr;

    // Work memory: queue for breadth-first, stack for depth-first
    logic [VW-1:0]      work_mem [WDEPTH];
    logic [VW-1:0]      work_rd_reg;
    logic               work_we;
    logic [WADDR_W-1:0] work_waddr;
    logic [VW-1:0]      work_wdata;
    logic               work_re;
    logic [WADDR_W-1:0] work_raddr;

    logic [3:0]              state_reg,      state_next;
    logic [CW-1:0]           vcount_reg,     vcount_next;
    logic [LINK_W-1:0]       used_reg,       used_next;
    logic [MAX_VERTICES-1:0] head_valid_reg, head_valid_next;
    logic [MAX_VERTICES-1:0] visited_reg,    visited_next;
    logic                    bfs_reg,        bfs_next;
    logic                    second_reg,     second_next;
    logic [VW-1:0]           owner_reg,      owner_next;
    logic [VW-1:0]           nbr_reg,        nbr_next;
    logic [VW-1:0]           v_reg,          v_next;
    logic [VW-1:0]           pend_v_reg,     pend_v_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [gtrav_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]        front_reg,      front_next;
    logic [CNT_W-1:0]        tail_reg,       tail_next;

    logic [CW-1:0]      cfg_sat;
    logic               a_ok;
    logic               b_ok;
    logic               edge_full;
    logic [VIDX_W-1:0]  a_idx;
    logic [VIDX_W-1:0]  owner_idx;
    logic [VIDX_W-1:0]  v_idx;
    logic [LADDR_W-1:0] owner_head_addr;
    logic [LADDR_W-1:0] v_head_addr;
    logic [LINK_W-1:0]  link_rd_next;
    logic [VW-1:0]      link_rd_nbr;
    logic [VIDX_W-1:0]  nbr_idx;
    logic               w_push;
    logic [VIDX_W-1:0]  work_rd_idx;
    logic               work_rd_ok;
    logic [CNT_W-1:0]   tail_dec;

    assign cfg_sat = (cfg_wdata == '0) ? CW'(1) :
                     (cfg_wdata > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cfg_wdata;

    assign a_ok      = {1'b0, item.vertex_a} < vcount_reg;
    assign b_ok      = {1'b0, item.vertex_b} < vcount_reg;
    assign edge_full = ({1'b0, used_reg} + (LINK_W + 1)'(2)) >
                       (LINK_W + 1)'(MAX_EDGE_ENTRIES);
    assign a_idx     = item.vertex_a[VIDX_W-1:0];
    assign owner_idx = owner_reg[VIDX_W-1:0];
    assign v_idx     = v_reg[VIDX_W-1:0];

    assign owner_head_addr = HEAD_BASE + LADDR_W'(owner_idx);
    assign v_head_addr     = HEAD_BASE + LADDR_W'(v_idx);

    assign link_rd_next = link_rd_reg[LINK_W-1:0];
    assign link_rd_nbr  = link_rd_reg[LWORD_W-1 -: VW];
    assign nbr_idx      = link_rd_nbr[VIDX_W-1:0];
    assign w_push       = ({1'b0, link_rd_nbr} < vcount_reg) && !visited_reg[nbr_idx] &&
                          (tail_reg < CNT_W'(WDEPTH));

    assign work_rd_idx = work_rd_reg[VIDX_W-1:0];
    assign work_rd_ok  = ({1'b0, work_rd_reg} < vcount_reg) && !visited_reg[work_rd_idx];
    assign tail_dec    = tail_reg - CNT_W'(1);

    always_comb begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        used_next       = used_reg;
        head_valid_next = head_valid_reg;
        visited_next    = visited_reg;
        bfs_next        = bfs_reg;
        second_next     = second_reg;
        owner_next      = owner_reg;
        nbr_next        = nbr_reg;
        v_next          = v_reg;
        pend_v_next     = pend_v_reg;
        pend_valid_next = pend_valid_reg;
        status_next     = status_reg;
        front_next      = front_reg;
        tail_next       = tail_reg;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_re    = 1'b0;
        link_raddr = '0;
        work_we    = 1'b0;
        work_waddr = '0;
        work_wdata = '0;
        work_re    = 1'b0;
        work_raddr = '0;

        cfg_ready  = (state_reg == S_IDLE);
        item_ready = (state_reg == S_IDLE) && !cfg_valid;
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    // Empty the graph: drop every list head, restart allocation
                    vcount_next     = cfg_sat;
                    used_next       = '0;
                    head_valid_next = '0;
                end else if (item_valid) begin
                    unique case (item.cmd) inside
                        gtrav_pkg::CMD_ADD_EDGE: begin
                            pend_v_next = '0;
                            if (!a_ok || !b_ok) begin
                                status_next = gtrav_pkg::ST_RANGE;
                                state_next  = S_FIN;
                            end else if (edge_full) begin
                                status_next = gtrav_pkg::ST_FULL;
                                state_next  = S_FIN;
                            end else begin
                                owner_next  = item.vertex_b;
                                nbr_next    = item.vertex_a;
                                second_next = 1'b0;
                                state_next  = S_E_RD;
                            end
                        end
                        gtrav_pkg::CMD_BFS, gtrav_pkg::CMD_DFS: begin
                            pend_v_next = '0;
                            if (!a_ok) begin
                                status_next = gtrav_pkg::ST_RANGE;
                                state_next  = S_FIN;
                            end else begin
                                bfs_next     = (item.cmd == gtrav_pkg::CMD_BFS);
                                visited_next = '0;
                                if (item.cmd == gtrav_pkg::CMD_BFS) begin
                                    visited_next[a_idx] = 1'b1;
                                end
                                work_we         = 1'b1;
                                work_waddr      = '0;
                                work_wdata      = item.vertex_a;
                                front_next      = '0;
                                tail_next       = CNT_W'(1);
                                pend_valid_next = 1'b0;
                                status_next     = gtrav_pkg::ST_OK;
                                state_next      = S_W_POP;
                            end
                        end
                        default: begin
                            // Unused command: drop without a result
                        end
                    endcase
                end
            end

            S_E_RD: begin
                link_re    = 1'b1;
                link_raddr = owner_head_addr;
                state_next = S_E_WE;
            end

            S_E_WE: begin
                link_we    = 1'b1;
                link_waddr = LADDR_W'(used_reg);
                link_wdata = {nbr_reg, head_valid_reg[owner_idx] ? link_rd_next : NIL};
                state_next = S_E_WH;
            end

            S_E_WH: begin
                link_we    = 1'b1;
                link_waddr = owner_head_addr;
                link_wdata = {VW'(0), used_reg};
                head_valid_next[owner_idx] = 1'b1;
                used_next  = used_reg + LINK_W'(1);
                if (second_reg) begin
                    status_next = gtrav_pkg::ST_OK;
                    state_next  = S_FIN;
                end else begin
                    owner_next  = nbr_reg;
                    nbr_next    = owner_reg;
                    second_next = 1'b1;
                    state_next  = S_E_RD;
                end
            end

            S_W_POP: begin
                if (bfs_reg) begin
                    if (front_reg < tail_reg) begin
                        work_re    = 1'b1;
                        work_raddr = front_reg[WADDR_W-1:0];
                        front_next = front_reg + CNT_W'(1);
                        state_next = S_W_GET;
                    end else begin
                        state_next = S_FIN;
                    end
                end else begin
                    if (tail_reg != '0) begin
                        work_re    = 1'b1;
                        work_raddr = tail_dec[WADDR_W-1:0];
                        tail_next  = tail_dec;
                        state_next = S_W_GET;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end

            S_W_GET: begin
                v_next = work_rd_reg;
                if (bfs_reg) begin
                    state_next = S_W_VIS;
                end else if (work_rd_ok) begin
                    visited_next[work_rd_idx] = 1'b1;
                    state_next = S_W_VIS;
                end else begin
                    state_next = S_W_POP;
                end
            end

            S_W_VIS: begin
                // Release the previous vertex; it is not the last one
                res_valid = pend_valid_reg;
                res       = '{visited_vertex: pend_v_reg, last: 1'b0,
                              status: gtrav_pkg::ST_OK};
                if (!pend_valid_reg || res_ready) begin
                    pend_v_next     = v_reg;
                    pend_valid_next = 1'b1;
                    if (head_valid_reg[v_idx]) begin
                        link_re    = 1'b1;
                        link_raddr = v_head_addr;
                        state_next = S_W_HEAD;
                    end else begin
                        state_next = S_W_POP;
                    end
                end
            end

            S_W_HEAD: begin
                link_re    = 1'b1;
                link_raddr = LADDR_W'(link_rd_next);
                state_next = S_W_SCAN;
            end

            S_W_SCAN: begin
                if (w_push) begin
                    work_we    = 1'b1;
                    work_waddr = tail_reg[WADDR_W-1:0];
                    work_wdata = link_rd_nbr;
                    tail_next  = tail_reg + CNT_W'(1);
                    if (bfs_reg) begin
                        visited_next[nbr_idx] = 1'b1;
                    end
                end
                if (link_rd_next != NIL) begin
                    link_re    = 1'b1;
                    link_raddr = LADDR_W'(link_rd_next);
                end else begin
                    state_next = S_W_POP;
                end
            end

            S_FIN: begin
                res_valid = 1'b1;
                res       = '{visited_vertex: pend_v_reg, last: 1'b1, status: status_reg};
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            vcount_reg     <= CW'(VC_RST);
            used_reg       <= '0;
            head_valid_reg <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            used_reg       <= used_next;
            head_valid_reg <= head_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        visited_reg <= visited_next;
        bfs_reg     <= bfs_next;
        second_reg  <= second_next;
        owner_reg   <= owner_next;
        nbr_reg     <= nbr_next;
        v_reg       <= v_next;
        pend_v_reg  <= pend_v_next;
        status_reg  <= status_next;
        front_reg   <= front_next;
        tail_reg    <= tail_next;
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (work_re) begin
            work_rd_reg <= work_mem[work_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- verif/graph_bfs_dfs_traversal_test.sv -----
`default_nettype none

import gtrav_pkg::*;

// Shadow copy of the graph store: adjacency lists, vertex count and the queue of
// results still owed by the block.
class graph_shadow;
    typedef logic [VERTEX_W-1:0] vtx_t;

    int unsigned vcount;
    int unsigned head [DEF_MAX_VERTICES];
    vtx_t        nbr [DEF_MAX_EDGE_ENTRIES];
    int unsigned next_entry [DEF_MAX_EDGE_ENTRIES];
    int unsigned used;
    out_item_t   pending_visits [$];
    int          fail_count;

    function new();
        fail_count = 0;
        set_vertex_count(VCOUNT_W'(VCOUNT_DEFAULT));
    endfunction

    // Clip the count into range and empty every list.
    function void set_vertex_count(logic [VCOUNT_W-1:0] value);
        vcount = 32'(value);
        if (vcount < 1)
            vcount = 1;
        if (vcount > DEF_MAX_VERTICES)
            vcount = DEF_MAX_VERTICES;
        foreach (head[i])
            head[i] = DEF_MAX_EDGE_ENTRIES;
        used = 0;
    endfunction

    function void emit(vtx_t v, logic is_last, logic [STATUS_W-1:0] st);
        out_item_t r;
        r.visited_vertex = v;
        r.last           = is_last;
        r.status         = st;
        pending_visits.push_back(r);
    endfunction

    function void prepend(vtx_t owner, vtx_t other);
        nbr[used]        = other;
        next_entry[used] = head[owner];
        head[owner]      = used;
        used++;
    endfunction

    function void walk_breadth(vtx_t start);
        vtx_t        fifo [$];
        bit          seen [DEF_MAX_VERTICES];
        int unsigned front;
        int unsigned e;
        vtx_t        v;
        vtx_t        w;
        seen[start] = 1'b1;
        fifo.push_back(start);
        front = 0;
        while (front < fifo.size()) begin
            v = fifo[front];
            front++;
            emit(v, 1'b0, ST_OK);
            for (e = head[v]; e < used; e = next_entry[e]) begin
                w = nbr[e];
                if (w < vcount && !seen[w] && fifo.size() < DEF_MAX_EDGE_ENTRIES + 1) begin
                    seen[w] = 1'b1;
                    fifo.push_back(w);
                end
            end
        end
    endfunction

    // Mark on pop; a vertex already marked is dropped without a scan.
    function void walk_depth(vtx_t start);
        vtx_t        stack [$];
        bit          seen [DEF_MAX_VERTICES];
        int unsigned e;
        vtx_t        v;
        vtx_t        w;
        stack.push_back(start);
        while (stack.size() > 0) begin
            v = stack.pop_back();
            if (v >= vcount || seen[v])
                continue;
            seen[v] = 1'b1;
            emit(v, 1'b0, ST_OK);
            for (e = head[v]; e < used; e = next_entry[e]) begin
                w = nbr[e];
                if (w < vcount && !seen[w] && stack.size() < DEF_MAX_EDGE_ENTRIES + 1)
                    stack.push_back(w);
            end
        end
    endfunction

    function void note_item(in_item_t it);
        if (it.cmd == CMD_NONE)
            return;
        if (it.vertex_a >= vcount || (it.cmd == CMD_ADD_EDGE && it.vertex_b >= vcount)) begin
            emit('0, 1'b1, ST_RANGE);
            return;
        end
        if (it.cmd == CMD_ADD_EDGE) begin
            if (used + 2 > DEF_MAX_EDGE_ENTRIES) begin
                emit('0, 1'b1, ST_FULL);
            end else begin
                prepend(it.vertex_b, it.vertex_a);
                prepend(it.vertex_a, it.vertex_b);
                emit('0, 1'b1, ST_OK);
            end
            return;
        end
        if (it.cmd == CMD_BFS)
            walk_breadth(it.vertex_a);
        else
            walk_depth(it.vertex_a);
        pending_visits[pending_visits.size() - 1].last = 1'b1;
    endfunction

    function void check_visit(out_item_t got);
        out_item_t want;
        if (pending_visits.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: vertex %0d last %0b status %0d",
                         got.visited_vertex, got.last, got.status);
            return;
        end
        want = pending_visits.pop_front();
        if (got.visited_vertex !== want.visited_vertex || got.last !== want.last ||
            got.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: want vertex %0d last %0b status %0d, got %0d %0b %0d",
                         want.visited_vertex, want.last, want.status,
                         got.visited_vertex, got.last, got.status);
        end
    endfunction
endclass

module graph_bfs_dfs_traversal_test;
    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 24;   // covers the edge latency and a dropped command
    localparam int LONG_HOLD     = 400;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [VCOUNT_W-1:0] cfg_wdata = '0;

    // quiet: both sides run without gaps. hold_request: receiver stalls for a long stretch.
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    graph_shadow shadow = new();

    graph_bfs_dfs_traversal uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #(CLK_PERIOD * 4000000);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: draw a gap per item, or hold off for a long stretch when asked,
    // then take the item and check it against the oldest outstanding prediction.
    initial begin
        int gap;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            shadow.check_visit(m_data);
        end
    end

    // Offer one item. Valid is left high after acceptance so that a back-to-back
    // item follows without a bubble; a gap or a drain drops it first.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned a,
                             input int unsigned b);
        in_item_t it;
        int       gap;
        it.cmd      = cmd;
        it.vertex_a = a[VERTEX_W-1:0];
        it.vertex_b = b[VERTEX_W-1:0];
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        shadow.note_item(it);
    endtask

    // Drop valid, wait for every owed result, then let the block go idle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (shadow.pending_visits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vcount(input logic [VCOUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow.set_vertex_count(value);
    endtask

    // Mostly in-range edges and walks so the graph grows; the rest is noise:
    // out-of-range vertices and the unused command.
    task automatic random_phase(input int n);
        int unsigned vc;
        int unsigned pick;
        vc = shadow.vcount;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_item(CMD_ADD_EDGE, $urandom_range(0, vc - 1), $urandom_range(0, vc - 1));
            else if (pick < 70)
                send_item(CMD_BFS, $urandom_range(0, vc - 1), $urandom_range(0, 63));
            else if (pick < 85)
                send_item(CMD_DFS, $urandom_range(0, vc - 1), $urandom_range(0, 63));
            else if (pick < 95)
                send_item(CMD_W'($urandom_range(0, 2)), $urandom_range(0, 63),
                          $urandom_range(0, 63));
            else
                send_item(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset count of 32: duplicate edge, self-loop, isolated start, walks
        // ignoring vertex_b, range errors on each endpoint and the dropped command.
        send_item(CMD_ADD_EDGE, 0, 31);
        send_item(CMD_ADD_EDGE, 31, 31);
        send_item(CMD_ADD_EDGE, 5, 0);
        send_item(CMD_ADD_EDGE, 0, 5);
        send_item(CMD_BFS, 0, 63);
        send_item(CMD_DFS, 0, 0);
        send_item(CMD_BFS, 31, 0);
        send_item(CMD_DFS, 7, 0);
        send_item(CMD_ADD_EDGE, 32, 0);
        send_item(CMD_ADD_EDGE, 0, 63);
        send_item(CMD_BFS, 63, 0);
        send_item(CMD_DFS, 32, 63);
        send_item(CMD_NONE, 63, 63);
        send_item(CMD_NONE, 0, 0);
        send_item(CMD_DFS, 5, 42);

        // Stall the receiver for a long stretch while items keep coming, so the
        // block fills up and holds off its input.
        hold_request = 1'b1;
        random_phase(20);
        drain_results();

        // Zero clips to a single vertex: only the self-loop on vertex 0 is legal.
        write_vcount(7'd0);
        send_item(CMD_ADD_EDGE, 0, 0);
        send_item(CMD_BFS, 0, 0);
        send_item(CMD_DFS, 0, 0);
        send_item(CMD_ADD_EDGE, 1, 0);
        send_item(CMD_BFS, 1, 0);
        drain_results();

        // All ones clips to the capacity; run this one without any gaps.
        write_vcount(7'h7f);
        quiet = 1'b1;
        random_phase(15);
        drain_results();
        quiet = 1'b0;

        write_vcount(7'd2);
        random_phase(10);
        drain_results();

        // Above capacity clips again; pause the sender midway until all is back.
        write_vcount(7'd64);
        random_phase(8);
        drain_results();
        random_phase(8);
        drain_results();

        repeat (3) begin
            write_vcount(VCOUNT_W'($urandom_range(1, 64)));
            random_phase(6);
            drain_results();
        end

        if (shadow.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
